/* hw/rtl/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// Shared sizes, types, codes and helpers for the set-associative LRU
// cache tag model.
// ----------------------------------------------------------------------------
package salc_pkg;

    // Cache geometry
    localparam int LINE_BYTES  = 32;
    localparam int TOTAL_LINES = 512;
    localparam int MAX_WAYS    = 16;

    // Derived widths
    localparam int IN_ADDR_W  = 64;
    localparam int OFFSET_W   = $clog2(LINE_BYTES);
    localparam int BLOCK_W    = IN_ADDR_W - OFFSET_W;
    localparam int LINE_IDX_W = $clog2(TOTAL_LINES);
    localparam int LANES      = MAX_WAYS;
    localparam int LANE_W     = $clog2(MAX_WAYS);
    localparam int ROWS       = TOTAL_LINES / LANES;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int RANK_W     = LANE_W;
    localparam int MAX_LG     = $clog2(MAX_WAYS);
    localparam int LG_W       = $clog2(MAX_LG + 1);
    localparam int CNT_W      = 32;

    // Configuration port
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STORE_ALLOC = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PREFETCH    = CFG_IDX_W'(2);

    // Prefetch mode codes
    localparam logic [1:0] PF_ALWAYS  = 2'd1;
    localparam logic [1:0] PF_ON_MISS = 2'd2;

    typedef logic [BLOCK_W-1:0] block_t;

    typedef struct packed {
        logic              valid;
        logic [RANK_W-1:0] rank;
    } line_state_t;

    typedef line_state_t [LANES-1:0] state_row_t;
    typedef block_t      [LANES-1:0] tag_row_t;

    // Request to the set update unit
    typedef struct packed {
        block_t            block;
        logic [LANE_W-1:0] lane_base;
        logic [LG_W-1:0]   lg;
        logic              allocate;
    } upd_req_t;

    // Status back from the set update unit
    typedef struct packed {
        logic hit;
        logic changed;
    } upd_resp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEM,
        ST_PRE,
        ST_WAIT
    } ctrl_state_t;

    // Mask of the lane bits inside one set: ways - 1
    function automatic logic [LANE_W-1:0] way_mask(input logic [LG_W-1:0] lg);
        logic [LANE_W:0] m;
        m = (LANE_W + 1)'(1) << lg;
        m = m - (LANE_W + 1)'(1);
        return m[LANE_W-1:0];
    endfunction

endpackage

/* hw/rtl/salc_ram.sv */
// ----------------------------------------------------------------------------
// salc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/salc_set_update.sv */
// ----------------------------------------------------------------------------
// salc_set_update
// Tag match, LRU victim pick and recency promotion for one set held in
// one memory row.
// ----------------------------------------------------------------------------
module salc_set_update
    import salc_pkg::*;
(
    input  upd_req_t   req,
    input  tag_row_t   tag_in,
    input  state_row_t state_in,
    output upd_resp_t  resp,
    output tag_row_t   tag_out,
    output state_row_t state_out
);

    logic [LANE_W-1:0] mask;
    logic [LANES-1:0]  in_set;
    logic [LANES-1:0]  match;
    logic [LANES-1:0]  lru;
    logic [LANES-1:0]  target;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] ref_rank;
    logic              hit;
    logic              changed;

    // Per-lane match and LRU detect
    always_comb
    begin
        mask     = way_mask(req.lg);
        hit_rank = '0;
        for (int k = 0; k < LANES; k++)
        begin
            in_set[k] = ((LANE_W'(k) ^ req.lane_base) & ~mask) == '0;
            match[k]  = in_set[k] && state_in[k].valid && (tag_in[k] == req.block);
            lru[k]    = in_set[k] && (state_in[k].rank == '0);
            hit_rank  = hit_rank | (match[k] ? state_in[k].rank : '0);
        end
        hit      = |match;
        target   = hit ? match : lru;
        ref_rank = hit ? hit_rank : '0;
        changed  = hit || req.allocate;
    end

    // Promote target to MRU, age the lanes above it
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            state_out[k] = state_in[k];
            tag_out[k]   = tag_in[k];
            if (changed)
            begin
                if (target[k])
                begin
                    state_out[k].rank  = mask;
                    state_out[k].valid = 1'b1;
                    if (!hit)
                    begin
                        tag_out[k] = req.block;
                    end
                end
                else if (in_set[k] && (state_in[k].rank > ref_rank))
                begin
                    state_out[k].rank = state_in[k].rank - RANK_W'(1);
                end
            end
        end
    end

    assign resp.hit     = hit;
    assign resp.changed = changed;

endmodule

/* hw/rtl/set_assoc_lru_cache_hit_model_unit.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_hit_model_unit
// A demand pass and then a prefetch pass run before an item's result is registered;
// a new item can be taken in the prefetch pass if the output is free. Each item makes
// two read-modify-write passes over the single-write-port row memories (demand set,
// next-line set). Reset: a clear over all 32 rows of the valid/recency memory, one row
// per cycle, no item taken; a ways_log2 write while idle redoes it. Counts reset to 0.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_hit_model_unit
    import salc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IN_ADDR_W-1:0] address,
    input  logic                 is_store,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [CNT_W-1:0]     hit_count,
    output logic [CNT_W-1:0]     access_count,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // First line of the set holding a block
    function automatic logic [LINE_IDX_W-1:0] line_base(input block_t b,
                                                       input logic [LG_W-1:0] lg);
        logic [LINE_IDX_W-1:0] idx;
        idx = b[LINE_IDX_W-1:0];
        return idx << lg;
    endfunction

    // Clamp the associativity setting to the supported range
    function automatic logic [LG_W-1:0] eff_lg(input logic [CFG_W-1:0] w);
        logic [LG_W-1:0] r;
        if (w == '0)
            r = LG_W'(1);
        else if (int'(w) > MAX_LG)
            r = LG_W'(MAX_LG);
        else
            r = LG_W'(w);
        return r;
    endfunction

    ctrl_state_t state_reg, state_next;

    logic [ROW_W-1:0] clr_cnt_reg;
    logic [LG_W-1:0]  lg_reg;
    logic             store_alloc_reg;
    logic [1:0]       pf_mode_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] acc_cnt_reg;
    logic             out_valid_reg;
    logic             fwd_reg;

    block_t           dem_block_reg;
    block_t           pre_block_reg;
    logic             store_reg;
    logic             dem_hit_reg;
    logic             out_hit_reg;
    logic [CNT_W-1:0] out_hit_cnt_reg;
    logic [CNT_W-1:0] out_acc_cnt_reg;
    tag_row_t         tag_fwd_data_reg;
    state_row_t       state_fwd_data_reg;

    logic in_stall_c;
    logic rd_pre;
    logic dem_upd;
    logic pre_stage;
    logic clr_active;
    logic finish;
    logic slot_free;
    logic accept;
    logic rd_en;
    logic pf_do;
    logic upd_we;
    logic lg_write;

    block_t                in_block;
    logic [LINE_IDX_W-1:0] in_base;
    logic [LINE_IDX_W-1:0] dem_base;
    logic [LINE_IDX_W-1:0] pre_base;
    logic [LINE_IDX_W-1:0] upd_base;
    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      upd_row;
    logic [ROW_W-1:0]      state_waddr;
    logic                  state_we;

    tag_row_t   tag_q;
    state_row_t state_q;
    tag_row_t   cur_tag;
    state_row_t cur_state;
    tag_row_t   tag_new;
    state_row_t state_new;
    state_row_t clear_row;
    state_row_t state_wdata;
    upd_req_t   req;
    upd_resp_t  resp;

    assign slot_free = !out_valid_reg || !out_stall;
    assign lg_write  = cfg_we && (cfg_index == REG_WAYS_LOG2);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                // a ways_log2 write restarts the sweep
                if (!lg_write && (clr_cnt_reg == ROW_W'(ROWS - 1)))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (lg_write)
                    state_next = ST_CLEAR;
                else if (accept)
                    state_next = ST_DEM;
            end
            ST_DEM:
            begin
                state_next = ST_PRE;
            end
            ST_PRE, ST_WAIT:
            begin
                if (!slot_free)
                    state_next = ST_WAIT;
                else if (accept)
                    state_next = ST_DEM;
                else
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall_c = 1'b1;
        rd_pre     = 1'b0;
        dem_upd    = 1'b0;
        pre_stage  = 1'b0;
        clr_active = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_active = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall_c = 1'b0;
            end
            ST_DEM:
            begin
                dem_upd = 1'b1;
                rd_pre  = 1'b1;
            end
            ST_PRE:
            begin
                pre_stage  = 1'b1;
                finish     = 1'b1;
                in_stall_c = !slot_free;
            end
            ST_WAIT:
            begin
                finish     = 1'b1;
                in_stall_c = !slot_free;
            end
            default:
            begin
                in_stall_c = 1'b1;
            end
        endcase
    end

    assign in_stall = in_stall_c;
    assign accept   = in_valid && !in_stall_c;
    assign rd_en    = accept || rd_pre;

    // Address decode
    assign in_block = address[IN_ADDR_W-1:OFFSET_W];
    assign in_base  = line_base(in_block, lg_reg);
    assign dem_base = line_base(dem_block_reg, lg_reg);
    assign pre_base = line_base(pre_block_reg, lg_reg);
    assign upd_base = pre_stage ? pre_base : dem_base;
    assign upd_row  = upd_base[LINE_IDX_W-1:LANE_W];
    assign rd_row   = rd_pre ? pre_base[LINE_IDX_W-1:LANE_W] : in_base[LINE_IDX_W-1:LANE_W];

    // Prefetch decision
    assign pf_do  = (pf_mode_reg == PF_ALWAYS) || ((pf_mode_reg == PF_ON_MISS) && !dem_hit_reg);
    assign upd_we = dem_upd || (pre_stage && pf_do);

    // Bypass a row written in the same cycle it was read
    assign cur_tag   = fwd_reg ? tag_fwd_data_reg : tag_q;
    assign cur_state = fwd_reg ? state_fwd_data_reg : state_q;

    // Shared set update unit: demand pass, then prefetch pass
    assign req.block     = pre_stage ? pre_block_reg : dem_block_reg;
    assign req.lane_base = upd_base[LANE_W-1:0];
    assign req.lg        = lg_reg;
    assign req.allocate  = pre_stage ? 1'b1 : !(store_reg && !store_alloc_reg);

    salc_set_update u_set_update (
        .req       (req),
        .tag_in    (cur_tag),
        .state_in  (cur_state),
        .resp      (resp),
        .tag_out   (tag_new),
        .state_out (state_new)
    );

    // Cleared row: invalid, rank is the way index within the set
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            clear_row[k].valid = 1'b0;
            clear_row[k].rank  = LANE_W'(k) & way_mask(lg_reg);
        end
    end

    assign state_we    = upd_we || clr_active;
    assign state_waddr = clr_active ? clr_cnt_reg : upd_row;
    assign state_wdata = clr_active ? clear_row : state_new;

    salc_ram #(
        .DATA_W ($bits(tag_row_t)),
        .ADDR_W (ROW_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (upd_we),
        .waddr (upd_row),
        .wdata (tag_new),
        .re    (rd_en),
        .raddr (rd_row),
        .rdata (tag_q)
    );

    salc_ram #(
        .DATA_W ($bits(state_row_t)),
        .ADDR_W (ROW_W)
    ) u_state_ram (
        .clk   (clk),
        .we    (state_we),
        .waddr (state_waddr),
        .wdata (state_wdata),
        .re    (rd_en),
        .raddr (rd_row),
        .rdata (state_q)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            lg_reg          <= LG_W'(1);
            store_alloc_reg <= 1'b1;
            pf_mode_reg     <= '0;
            hit_cnt_reg     <= '0;
            acc_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            fwd_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fwd_reg   <= rd_en && upd_we && (upd_row == rd_row);

            // Clearing sweep
            if (lg_write)
                clr_cnt_reg <= '0;
            else if (clr_active)
                clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);

            // Configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WAYS_LOG2:   lg_reg          <= eff_lg(cfg_data);
                    REG_STORE_ALLOC: store_alloc_reg <= cfg_data[0];
                    REG_PREFETCH:    pf_mode_reg     <= cfg_data[1:0];
                    default:         ;
                endcase
            end

            // Saturating counts on the demand pass
            if (dem_upd)
            begin
                if (resp.hit && (hit_cnt_reg != '1))
                    hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                if (acc_cnt_reg != '1)
                    acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
            end

            // Output register handshake
            if (finish && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dem_block_reg <= in_block;
            pre_block_reg <= in_block + BLOCK_W'(1);
            store_reg     <= is_store;
        end
        if (dem_upd)
        begin
            dem_hit_reg <= resp.hit;
        end
        if (upd_we)
        begin
            tag_fwd_data_reg   <= tag_new;
            state_fwd_data_reg <= state_new;
        end
        if (finish && slot_free)
        begin
            out_hit_reg     <= dem_hit_reg;
            out_hit_cnt_reg <= hit_cnt_reg;
            out_acc_cnt_reg <= acc_cnt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign hit_count    = out_hit_cnt_reg;
    assign access_count = out_acc_cnt_reg;

`ifndef NO_ASSERTIONS
    // No item enters during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !accept)
        else $error("item accepted during clearing sweep");

    // A result only appears after an item finished its passes
    a_out_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_PRE || state_reg == ST_WAIT))
        else $error("result valid without a finished item");

    // Access count moves only on a demand pass
    a_acc_only_demand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DEM) |=> $stable(acc_cnt_reg))
        else $error("access count changed outside demand pass");

    // Hits never exceed accesses
    a_hits_le_access: assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg <= acc_cnt_reg)
        else $error("hit count above access count");
`endif

endmodule

/* sim/salc_lookup_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// salc_lookup_checker
// Watches the access, result and register-write ports of the cache tag model.
// Keeps its own tag, valid and recency arrays plus the three settings, and
// works out the hit flag and both running counts for every accepted access.
// Each accepted result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module salc_lookup_checker
    import salc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [IN_ADDR_W-1:0] address,
    input  logic                 is_store,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 hit,
    input  logic [CNT_W-1:0]     hit_count,
    input  logic [CNT_W-1:0]     access_count,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   error_count,
    output int                   outstanding
);

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] accesses;
    } lookup_result_t;

    // Shadow copy of the cache tag store
    block_t            tag_mem   [TOTAL_LINES];
    logic              valid_mem [TOTAL_LINES];
    logic [LANE_W-1:0] rank_mem  [TOTAL_LINES];

    logic [CFG_W-1:0] ways_cfg;
    logic             alloc_cfg;
    logic [1:0]       pf_cfg;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] access_total;

    lookup_result_t lookup_q[$];
    int             errs;

    // Associativity actually used: 0 acts as 1, too many ways are cut back
    function automatic int active_lg();
        int w;
        w = int'(ways_cfg);
        if (w < 1)
            w = 1;
        while ((1 << w) > MAX_WAYS)
            w--;
        return w;
    endfunction

    function automatic void flush_all();
        int ways;
        ways = 1 << active_lg();
        for (int i = 0; i < TOTAL_LINES; i++)
        begin
            valid_mem[i] = 1'b0;
            rank_mem[i]  = LANE_W'(i & (ways - 1));
        end
    endfunction

    function automatic void make_mru(int base, int ways, int way);
        logic [LANE_W-1:0] r;
        r = rank_mem[base + way];
        for (int k = 0; k < ways; k++)
            if (rank_mem[base + k] > r)
                rank_mem[base + k] = rank_mem[base + k] - 1'b1;
        rank_mem[base + way] = LANE_W'(ways - 1);
    endfunction

    // Look a block up in its set; on a miss optionally replace the LRU way
    function automatic logic probe_set(block_t blk, logic allocate);
        int   lg;
        int   ways;
        int   sets;
        int   base;
        int   victim;
        logic found;
        logic picked;
        lg     = active_lg();
        ways   = 1 << lg;
        sets   = TOTAL_LINES >> lg;
        base   = int'(blk % sets) << lg;
        found  = 1'b0;
        picked = 1'b0;
        victim = 0;
        for (int k = 0; k < ways; k++)
        begin
            if (!found && valid_mem[base + k] && tag_mem[base + k] == blk)
            begin
                make_mru(base, ways, k);
                found = 1'b1;
            end
        end
        if (!found && allocate)
        begin
            for (int k = 0; k < ways; k++)
            begin
                if (!picked && rank_mem[base + k] == '0)
                begin
                    victim = k;
                    picked = 1'b1;
                end
            end
            make_mru(base, ways, victim);
            tag_mem[base + victim]   = blk;
            valid_mem[base + victim] = 1'b1;
        end
        return found;
    endfunction

    // Demand lookup, then the next-line prefetch, then the saturating counts
    function automatic lookup_result_t predict_lookup(logic [IN_ADDR_W-1:0] addr,
                                                      logic st);
        lookup_result_t res;
        block_t         blk;
        logic           dem_hit;
        blk     = addr[IN_ADDR_W-1:OFFSET_W];
        dem_hit = probe_set(blk, !(st && !alloc_cfg));
        // next block wraps to zero past the top through the block width
        if (pf_cfg == PF_ALWAYS || (pf_cfg == PF_ON_MISS && !dem_hit))
            void'(probe_set(blk + block_t'(1), 1'b1));
        if (dem_hit && hit_total != '1)
            hit_total = hit_total + 1'b1;
        if (access_total != '1)
            access_total = access_total + 1'b1;
        res.hit      = dem_hit;
        res.hits     = hit_total;
        res.accesses = access_total;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            errs++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_cfg     = CFG_W'(1);
            alloc_cfg    = 1'b1;
            pf_cfg       = '0;
            hit_total    = '0;
            access_total = '0;
            for (int i = 0; i < TOTAL_LINES; i++)
                tag_mem[i] = '0;
            flush_all();
            lookup_q.delete();
            errs = 0;
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // register writes must only be made while the block is idle; this checker does not enforce it
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WAYS_LOG2:
                    begin
                        ways_cfg = cfg_data;
                        flush_all();
                    end
                    REG_STORE_ALLOC: alloc_cfg = cfg_data[0];
                    REG_PREFETCH:    pf_cfg    = cfg_data[1:0];
                    default:         ;
                endcase
            end

            if (in_valid && !in_stall)
                lookup_q.insert(lookup_q.size(), predict_lookup(address, is_store));

            if (out_valid && !out_stall)
            begin
                if (lookup_q.size() == 0)
                begin
                    errs++;
                    $display("%0t ns: stray result, expected none, actual %0d %0d/%0d",
                             $time, hit, hit_count, access_count);
                end
                else
                begin
                    lookup_result_t want;
                    want = lookup_q.pop_front();
                    check_field("hit", CNT_W'(want.hit), CNT_W'(hit));
                    check_field("hit_count", want.hits, hit_count);
                    check_field("access_count", want.accesses, access_count);
                end
            end

            error_count <= errs;
            outstanding <= lookup_q.size();
        end
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives accesses and register writes into the set-associative LRU cache tag
// model: a short directed list for the corner cases, then random phases of
// local, streaming and scattered accesses under changing settings, with
// random idle bursts on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top
    import salc_pkg::*;
();

    localparam logic [1:0] PF_UNUSED = 2'd3;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RAND_PHASES    = 11;
    localparam int PHASE_ITEMS    = 80;
    localparam int HIST_DEPTH     = 16;
    localparam int REGIONS        = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [IN_ADDR_W-1:0] address;
    logic                 is_store;
    logic                 out_valid;
    logic                 out_stall;
    logic                 hit;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     access_count;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int error_count;
    int outstanding;

    // Knobs shared by the stimulus and the output-stall process
    int gap_pct;
    int stall_pct;
    bit holdoff_req;
    bit holdoff_done;

    int idle_cycles;
    int items_sent;
    int stores_sent;
    int settings_seen;

    // Address generator state
    logic [IN_ADDR_W-1:0] recent_addr [HIST_DEPTH];
    logic [IN_ADDR_W-1:0] region_base [REGIONS];
    logic [IN_ADDR_W-1:0] stream_ptr;
    int                   hist_wr;
    int                   hist_fill;

    set_assoc_lru_cache_hit_model_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .address      (address),
        .is_store     (is_store),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_count    (hit_count),
        .access_count (access_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    salc_lookup_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .address      (address),
        .is_store     (is_store),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_count    (hit_count),
        .access_count (access_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        holdoff_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req && !holdoff_done)
            begin
                holdoff_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which no item and no register write goes through
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one access, after an optional idle burst, and wait until taken
    task automatic push_access(input logic [IN_ADDR_W-1:0] addr, input logic st);
        int gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= addr;
        is_store <= st;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (st)
            stores_sent++;
    endtask

    // Drain the block, then write the registers back to back
    task automatic apply_settings(input logic [CFG_W-1:0] ways, input logic alloc,
                                  input logic [1:0] pf, input bit write_ways);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // one result per item, but let the prefetch pass settle too
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (write_ways)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_WAYS_LOG2;
            cfg_data  <= ways;
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= REG_STORE_ALLOC;
        cfg_data  <= CFG_W'(alloc);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PREFETCH;
        cfg_data  <= CFG_W'(pf);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_seen++;
    endtask

    // Mix of reuse, sequential streams, clustered and fully random addresses
    function automatic logic [IN_ADDR_W-1:0] pick_address();
        logic [IN_ADDR_W-1:0] a;
        int                   sel;
        sel = $urandom_range(0, 99);
        if (sel < 35 && hist_fill > 0)
        begin
            a = recent_addr[$urandom_range(0, hist_fill - 1)];
            a[OFFSET_W-1:0] = OFFSET_W'($urandom);
        end
        else if (sel < 60)
        begin
            stream_ptr = stream_ptr + LINE_BYTES;
            a = stream_ptr;
            if ($urandom_range(0, 31) == 0)
                stream_ptr = region_base[$urandom_range(0, REGIONS - 1)];
        end
        else if (sel < 92)
            a = region_base[$urandom_range(0, REGIONS - 1)] + $urandom_range(0, 16'hFFFF);
        else
            a = {$urandom, $urandom};
        recent_addr[hist_wr] = a;
        hist_wr = (hist_wr + 1) % HIST_DEPTH;
        if (hist_fill < HIST_DEPTH)
            hist_fill++;
        return a;
    endfunction

    initial
    begin
        logic [CFG_W-1:0] ways;
        bit               write_ways;
        bit               quiet;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        address   <= '0;
        is_store  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_WAYS_LOG2;
        cfg_data  <= '0;
        gap_pct       = 0;
        stall_pct     = 0;
        holdoff_req   = 1'b0;
        items_sent    = 0;
        stores_sent   = 0;
        settings_seen = 1;
        hist_wr       = 0;
        hist_fill     = 0;
        stream_ptr    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: 2 ways, allocate on store, no prefetch
        push_access(64'h0, 1'b0);
        push_access(64'h1F, 1'b0);
        push_access(64'h0, 1'b1);
        push_access('1, 1'b0);
        push_access(64'hFFFF_FFFF_FFFF_FFE0, 1'b1);
        // three blocks in set 0 of a 2-way cache: LRU eviction
        push_access(64'h2000, 1'b0);
        push_access(64'h4000, 1'b0);
        push_access(64'h0, 1'b0);

        // Zero associativity acts as 2 ways; store miss without allocate
        apply_settings(CFG_W'(0), 1'b0, PF_ALWAYS, 1'b1);
        push_access(64'h1000, 1'b1);
        push_access(64'h1000, 1'b0);
        push_access(64'h1020, 1'b0);
        // prefetch past the top block wraps to block 0
        push_access('1, 1'b0);
        push_access(64'h0, 1'b1);
        push_access(64'h3F, 1'b1);

        // Oversized associativity cut to 16 ways; unused prefetch code
        apply_settings(CFG_W'(7), 1'b1, PF_UNUSED, 1'b1);
        push_access(64'h2000, 1'b1);
        push_access(64'h2000, 1'b1);
        push_access(64'h2020, 1'b0);
        push_access(64'h2000, 1'b0);

        // 16 ways, prefetch only on a demand miss
        apply_settings(CFG_W'(4), 1'b1, PF_ON_MISS, 1'b1);
        push_access(64'h5000, 1'b0);
        push_access(64'h5020, 1'b0);
        push_access(64'h5040, 1'b0);
        push_access(64'h8000_0000_0000_0000, 1'b1);
        push_access(64'h8000_0000_0000_0020, 1'b0);

        // Random phases, each under fresh settings and idling levels
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            if (phase < 4)
                ways = CFG_W'(phase + 1);
            else
                ways = CFG_W'($urandom_range(0, 7));
            write_ways = (phase < 4) || ($urandom_range(0, 3) != 0);
            apply_settings(ways, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                           write_ways);

            for (int r = 0; r < REGIONS; r++)
                region_base[r] = {$urandom, $urandom};
            // one region sits just under the top of the address space
            region_base[REGIONS - 1] = '1 - 64'h8000;
            stream_ptr = region_base[$urandom_range(0, REGIONS - 1)];

            quiet = (phase == 2) || (phase == 5) || (phase == RAND_PHASES - 1);
            gap_pct   = quiet ? 0 : $urandom_range(5, 40);
            stall_pct = quiet ? 0 : $urandom_range(5, 40);
            if (phase == 2)
                holdoff_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
                push_access(pick_address(), $urandom_range(0, 2) == 0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d accesses (%0d stores) under %0d cache settings,",
                 items_sent, stores_sent, settings_seen);
        $display("2 to 16 ways, all prefetch codes, with and without store allocation.");
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
